### src/mtau_pkg.sv
// ----------------------------------------------------------------------------
// mtau_pkg : shared types and constants of the multi-turn angle unwrapper
// Field widths, register map and the structs between the core and its
// angle update datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package mtau_pkg;

   // field widths
   localparam int JSEL_W     = 3;
   localparam int ANGLE_W    = 18;
   localparam int RATE_W     = 32;
   localparam int ACC_W      = 32;
   localparam int DEADBAND_W = 16;

   // stream word layout
   localparam int REQ_DATA_W = 56;   // wrapped_angle + angular_rate, padded to bytes
   localparam int RSP_DATA_W = 32;

   // register port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic CSR_IDX_DEADBAND = 1'b0;
   localparam logic [DEADBAND_W-1:0] DEADBAND_RESET = 16'd66;

   // control into the update datapath
   typedef struct packed {
      logic rate_pos;                 // angular rate is non-negative
   } mtau_step_ctl_type;

   // result of the update datapath
   typedef struct packed {
      logic signed [ACC_W-1:0] angle;
      logic                    sat;
   } mtau_step_res_type;

endpackage

`default_nettype wire

### src/mtau_step.sv
// ----------------------------------------------------------------------------
// mtau_step : multi-turn angle update datapath
// Splits the stored angle into half-turn parity and remainder, picks the
// correction from the direction table and adds it with saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module mtau_step #(
   parameter int HALF_TURN_FRACTION_BITS = 16
) (
   input  wire logic signed [mtau_pkg::ACC_W-1:0]   past,
   input  wire logic signed [mtau_pkg::ANGLE_W-1:0] cur,
   input  wire mtau_pkg::mtau_step_ctl_type         ctl,
   output mtau_pkg::mtau_step_res_type              res
);
   import mtau_pkg::*;

   localparam int F      = HALF_TURN_FRACTION_BITS;
   localparam int WIDE_W = ACC_W + 2;
   localparam logic signed [WIDE_W-1:0] PI_W =
      $signed({{(WIDE_W-1-F){1'b0}}, 1'b1, {F{1'b0}}});
   localparam logic signed [WIDE_W-1:0] TWO_PI_W = PI_W <<< 1;
   localparam logic signed [WIDE_W-1:0] MAX_W =
      $signed({{(WIDE_W-ACC_W+1){1'b0}}, {(ACC_W-1){1'b1}}});
   localparam logic signed [WIDE_W-1:0] MIN_W = -MAX_W - WIDE_W'(1);

   logic        [ACC_W-1:0]  mag;
   logic                     odd;
   logic                     pos;
   logic                     cneg;
   logic signed [WIDE_W-1:0] rem_w;
   logic signed [WIDE_W-1:0] rem_term;
   logic signed [WIDE_W-1:0] pi_term;
   logic signed [WIDE_W-1:0] sum;

   // split the stored angle; the most negative value gives 2^31 unsigned
   assign mag   = past[ACC_W-1] ? (~past + ACC_W'(1)) : past;
   assign odd   = mag[F];
   assign rem_w = $signed({{(WIDE_W-F){1'b0}}, mag[F-1:0]});
   assign pos   = !past[ACC_W-1];
   assign cneg  = cur[ANGLE_W-1];   // zero counts as non-negative

   // pick the half-turn correction from rate sign, angle sign, parity and cur sign
   always_comb begin
      rem_term = pos ? -rem_w : rem_w;
      if (ctl.rate_pos && pos) begin
         pi_term = odd ? PI_W : (cneg ? TWO_PI_W : '0);
      end else if (ctl.rate_pos) begin
         pi_term = odd ? (cneg ? PI_W : -PI_W) : '0;
      end else if (pos) begin
         pi_term = odd ? (cneg ? PI_W : -PI_W) : '0;
      end else begin
         pi_term = odd ? -PI_W : (cneg ? '0 : -TWO_PI_W);
      end
   end

   assign sum = WIDE_W'(past) + WIDE_W'(cur) + rem_term + pi_term;

   // clamp to the accumulator range
   always_comb begin
      if (sum > MAX_W) begin
         res.angle = MAX_W[ACC_W-1:0];
         res.sat   = 1'b1;
      end else if (sum < MIN_W) begin
         res.angle = MIN_W[ACC_W-1:0];
         res.sat   = 1'b1;
      end else begin
         res.angle = sum[ACC_W-1:0];
         res.sat   = 1'b0;
      end
   end

endmodule

`default_nettype wire

### src/multi_turn_angle_unwrap_core.sv
// ----------------------------------------------------------------------------
// multi_turn_angle_unwrap_core : per-joint multi-turn angle unwrapper
// Keeps one accumulated angle per joint in a small synchronous memory and
// updates it from each wrapped angle and rate word outside the rate deadband.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake        | contents
//  req_     | in        | tvalid / tready  | joint select, wrapped angle, rate
//  rsp_     | out       | tvalid / tready  | unwrapped angle, saturated flag
//  csr_     | in / out  | APB, pready high | rate deadband register
//
//  One word per cycle sustained while the result stream is not stalled; at
//  acceptance the memory read and the word's fields are registered into the
//  update stage, and the update through the add and clamp is then written to
//  the result register and back to the memory at the same edge.
//  Back-to-back words for one joint are served by forwarding the write data.
//  Reset clears the per-joint valid bits at once; no clearing pass is needed.
//  A stalled result holds the update stage; further words wait behind it.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_turn_angle_unwrap_core #(
   parameter int JOINTS                  = 8,
   parameter int HALF_TURN_FRACTION_BITS = 16
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // request stream
   input  wire logic                               req_tvalid,
   output      logic                               req_tready,
   // [17:0] wrapped_angle, [49:18] angular_rate, [55:50] zero
   input  wire logic [mtau_pkg::REQ_DATA_W-1:0]    req_tdata,
   // [2:0] joint_select
   input  wire logic [mtau_pkg::JSEL_W-1:0]        req_tuser,
   // result stream
   output      logic                               rsp_tvalid,
   input  wire logic                               rsp_tready,
   // [31:0] unwrapped_angle
   output      logic [mtau_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // [0] saturated
   output      logic                               rsp_tuser,
   // register port
   input  wire logic                               csr_psel,
   input  wire logic                               csr_penable,
   input  wire logic                               csr_pwrite,
   input  wire logic [mtau_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  wire logic [mtau_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output      logic [mtau_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output      logic                               csr_pready
);
   import mtau_pkg::*;

   localparam int IDX_W     = (JOINTS > 1) ? $clog2(JOINTS) : 1;
   localparam int SEL_EXT_W = (IDX_W > JSEL_W) ? IDX_W : JSEL_W;

   // register port
   logic [DEADBAND_W-1:0] deadband_ff;
   logic                  csr_wr;

   // request decode
   logic                      req_acc;
   logic [SEL_EXT_W-1:0]      req_sel_ext;
   logic [IDX_W-1:0]          req_idx;
   logic                      req_range_ok;
   logic signed [ANGLE_W-1:0] req_cur;
   logic signed [RATE_W-1:0]  req_rate;
   logic [RATE_W-1:0]         req_rate_abs;
   logic                      req_still;

   // state memory and valid bits
   logic signed [ACC_W-1:0] angle_mem_ff [JOINTS];
   logic [JOINTS-1:0]       valid_ff;
   logic signed [ACC_W-1:0] rd_data_ff;
   logic                    rd_valid_ff;
   logic                    fwd_hit_ff;
   logic signed [ACC_W-1:0] fwd_data_ff;
   logic                    fwd_hit_in;

   // update stage
   logic                      s1_valid_ff;
   logic [IDX_W-1:0]          s1_idx_ff;
   logic signed [ANGLE_W-1:0] s1_cur_ff;
   logic                      s1_rate_pos_ff;
   logic                      s1_still_ff;
   logic                      s1_range_ok_ff;
   logic                      s1_adv;
   logic                      wr_en;
   logic signed [ACC_W-1:0]   past;
   mtau_step_ctl_type         step_ctl;
   mtau_step_res_type         step_res;

   // result register
   logic                  rsp_valid_ff;
   logic [ACC_W-1:0]      rsp_angle_ff;
   logic                  rsp_sat_ff;
   logic [ACC_W-1:0]      rsp_angle_in;
   logic                  rsp_sat_in;

   // ---------------------------------------------------------------- register
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr[2] == CSR_IDX_DEADBAND);
   assign csr_prdata = (csr_paddr[2] == CSR_IDX_DEADBAND)
                       ? CSR_DATA_W'(deadband_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         deadband_ff <= DEADBAND_RESET;
      end else if (csr_wr) begin
         deadband_ff <= csr_pwdata[DEADBAND_W-1:0];
      end
   end

   // ---------------------------------------------------------------- handshake
   assign s1_adv     = !rsp_valid_ff || rsp_tready;
   assign req_tready = !s1_valid_ff || s1_adv;
   assign req_acc    = req_tvalid && req_tready;

   // decode the incoming word
   assign req_sel_ext  = SEL_EXT_W'(req_tuser);
   assign req_idx      = req_sel_ext[IDX_W-1:0];
   assign req_range_ok = (int'(req_tuser) < JOINTS);
   assign req_cur      = $signed(req_tdata[ANGLE_W-1:0]);
   assign req_rate     = $signed(req_tdata[ANGLE_W+RATE_W-1:ANGLE_W]);
   assign req_rate_abs = req_rate[RATE_W-1] ? (~req_rate + RATE_W'(1)) : req_rate;
   assign req_still    = (req_rate == '0) || (req_rate_abs < RATE_W'(deadband_ff));

   // ---------------------------------------------------------------- memory
   assign wr_en      = s1_valid_ff && s1_adv && s1_range_ok_ff && !s1_still_ff;
   assign fwd_hit_in = wr_en && (s1_idx_ff == req_idx);

   // write back the update, read the next word's joint
   always_ff @(posedge clock) begin
      if (wr_en) begin
         angle_mem_ff[s1_idx_ff] <= step_res.angle;
      end
      if (req_acc) begin
         rd_data_ff  <= angle_mem_ff[req_idx];
         rd_valid_ff <= valid_ff[req_idx];
         fwd_hit_ff  <= fwd_hit_in;
         fwd_data_ff <= step_res.angle;
      end
   end

   // mark joints written since reset; unwritten joints read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[s1_idx_ff] <= 1'b1;
      end
   end

   // ---------------------------------------------------------------- update stage
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_acc;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         s1_idx_ff      <= req_idx;
         s1_cur_ff      <= req_cur;
         s1_rate_pos_ff <= !req_rate[RATE_W-1];
         s1_still_ff    <= req_still;
         s1_range_ok_ff <= req_range_ok;
      end
   end

   // take the freshest stored angle
   assign past = fwd_hit_ff ? fwd_data_ff : (rd_valid_ff ? rd_data_ff : '0);

   assign step_ctl.rate_pos = s1_rate_pos_ff;

   mtau_step #(
      .HALF_TURN_FRACTION_BITS (HALF_TURN_FRACTION_BITS)
   ) u_step (
      .past (past),
      .cur  (s1_cur_ff),
      .ctl  (step_ctl),
      .res  (step_res)
   );

   // select the result word
   always_comb begin
      if (!s1_range_ok_ff) begin
         rsp_angle_in = '0;
         rsp_sat_in   = 1'b0;
      end else if (s1_still_ff) begin
         rsp_angle_in = past;
         rsp_sat_in   = 1'b0;
      end else begin
         rsp_angle_in = step_res.angle;
         rsp_sat_in   = step_res.sat;
      end
   end

   // ---------------------------------------------------------------- result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_adv) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv && s1_valid_ff) begin
         rsp_angle_ff <= rsp_angle_in;
         rsp_sat_ff   <= rsp_sat_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_angle_ff;
   assign rsp_tuser  = rsp_sat_ff;

endmodule

`default_nettype wire

### src/mtau_checker.sv
// ----------------------------------------------------------------------------
// mtau_checker : port-level checks of the multi-turn angle unwrapper
// Watches the result stream and the register port of the core.
// ----------------------------------------------------------------------------
`default_nettype none

module mtau_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            rsp_tvalid,
   input wire logic                            rsp_tready,
   input wire logic [mtau_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input wire logic                            rsp_tuser,
   input wire logic                            csr_psel,
   input wire logic                            csr_penable,
   input wire logic                            csr_pwrite,
   input wire logic [mtau_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input wire logic [mtau_pkg::CSR_DATA_W-1:0] csr_pwdata,
   input wire logic [mtau_pkg::CSR_DATA_W-1:0] csr_prdata,
   input wire logic                            csr_pready
);
   import mtau_pkg::*;

   // hold a stalled result word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result word changed while stalled");

   // drop results on reset
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // a clamped result sits at a range limit
   a_sat_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> (rsp_tdata == 32'h7FFF_FFFF || rsp_tdata == 32'h8000_0000))
      else $error("saturated flag without a limit value");

   // a deadband write reads back at once
   a_csr_readback: assert property (@(posedge clock) disable iff (reset)
      csr_psel && csr_penable && csr_pwrite && !csr_paddr[2]
      ##1 csr_psel && !csr_pwrite && !csr_paddr[2] && !$past(reset, 1)
      |-> csr_prdata == {16'h0000, $past(csr_pwdata[15:0])})
      else $error("deadband read-back mismatch");

   // the register port never waits
   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_psel |-> csr_pready)
      else $error("register port not ready");

endmodule

bind multi_turn_angle_unwrap_core mtau_checker u_mtau_checker (.*);

`default_nettype wire
